>>> design/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros shared by the unpacker modules
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is high
`define PIU_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled while reset is high
`define PIU_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> design/piu_pkg.sv
// ----------------------------------------------------------------------------
// piu_pkg
// types, codes and constants shared by the packed index unpacker
// ----------------------------------------------------------------------------
package piu_pkg;

   localparam int SECTION_ENTRIES_DEF = 4096;
   localparam int PALETTE_DEPTH_DEF   = 512;
   localparam int WORD_BITS           = 64;
   localparam int MAX_INDEX_BITS      = 16;

   // transaction kinds
   localparam logic ACT_PALETTE_WRITE = 1'b0;
   localparam logic ACT_DATA_WORD     = 1'b1;

   // register indexes
   localparam logic [1:0] CSR_PACKING_MODE   = 2'd0;
   localparam logic [1:0] CSR_BITS_PER_INDEX = 2'd1;
   localparam logic [1:0] CSR_PALETTE_COUNT  = 2'd2;

   // register reset values
   localparam logic       RST_PACKING_MODE   = 1'b0;
   localparam logic [4:0] RST_BITS_PER_INDEX = 5'd4;
   localparam logic [9:0] RST_PALETTE_COUNT  = 10'd0;

   typedef struct packed {
      logic       packing_mode;
      logic [4:0] bits_per_index;
      logic [9:0] palette_count;
   } cfg_type;

   // control travelling from the issue stage to the lookup pipeline
   typedef struct packed {
      logic wr_en;
      logic rd_en;
      logic in_range;
      logic last_word;
      logic last_sect;
   } issue_ctl_type;

endpackage

>>> design/piu_unpack.sv
// ----------------------------------------------------------------------------
// piu_unpack
// holds one transaction, issues one palette write or one index a cycle while s1_ready
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module piu_unpack #(
   parameter int SECTION_ENTRIES = piu_pkg::SECTION_ENTRIES_DEF,
   parameter int PALETTE_DEPTH   = piu_pkg::PALETTE_DEPTH_DEF,
   localparam int CW = $clog2(SECTION_ENTRIES),
   localparam int AW = $clog2(PALETTE_DEPTH)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  piu_pkg::cfg_type       cfg,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic                   req_action,
   input  logic [8:0]             req_palette_slot,
   input  logic [7:0]             req_palette_value,
   input  logic [63:0]            req_packed_word,
   input  logic                   s1_ready,
   output piu_pkg::issue_ctl_type issue,
   output logic [15:0]            issue_idx,
   output logic [CW-1:0]          issue_entry,
   output logic [AW-1:0]          wr_addr,
   output logic [7:0]             wr_value
);

   logic          cur_valid_ff, cur_valid_in;
   logic          cur_action_ff, cur_action_in;
   logic [8:0]    cur_slot_ff, cur_slot_in;
   logic [7:0]    cur_value_ff, cur_value_in;
   logic [63:0]   word_ff, word_in;
   logic          first_ff, first_in;
   logic [6:0]    pos_ff, pos_in;
   logic          pend_ff, pend_in;
   logic [15:0]   part_ff, part_in;
   logic [6:0]    held_ff, held_in;
   logic [CW-1:0] cnt_ff, cnt_in;

   logic [4:0]  bits;
   logic [6:0]  bits7;
   logic [15:0] mask;
   logic        is_write, is_data, use_partial, end_sec, more, last, fire;
   logic        cur_done, accept, in_range;
   logic [6:0]  partial_pos, pos_next;
   logic [4:0]  shamt;
   logic [15:0] idx;
   logic [63:0] word_sh;

   always_comb begin
      // clamp the index width into 1..16
      if (cfg.bits_per_index == 5'd0) begin
         bits = 5'd1;
      end else if (cfg.bits_per_index > 5'(piu_pkg::MAX_INDEX_BITS)) begin
         bits = 5'(piu_pkg::MAX_INDEX_BITS);
      end else begin
         bits = cfg.bits_per_index;
      end
      bits7 = 7'(bits);
      mask  = 16'((17'd1 << bits) - 17'd1);

      is_write    = cur_valid_ff && (cur_action_ff == piu_pkg::ACT_PALETTE_WRITE);
      is_data     = cur_valid_ff && (cur_action_ff == piu_pkg::ACT_DATA_WORD);
      use_partial = first_ff && cfg.packing_mode && pend_ff;
      partial_pos = (bits7 > held_ff) ? (bits7 - held_ff) : 7'd0;
      pos_next    = use_partial ? partial_pos : (pos_ff + bits7);
      shamt       = use_partial ? partial_pos[4:0] : bits;
      word_sh     = word_ff >> shamt;

      if (use_partial) begin
         idx = (part_ff | (word_ff[15:0] << held_ff[5:0])) & mask;
      end else begin
         idx = word_ff[15:0] & mask;
      end

      end_sec  = (cnt_ff == CW'(SECTION_ENTRIES - 1));
      more     = (8'(pos_next) + 8'(bits)) <= 8'(piu_pkg::WORD_BITS);
      last     = end_sec || !more;
      fire     = is_data && s1_ready;
      cur_done = is_write || (fire && last);
      req_stall = cur_valid_ff && !cur_done;
      accept    = req_valid && !req_stall;
      in_range  = (idx < 16'(cfg.palette_count)) && (32'(idx) < PALETTE_DEPTH);

      issue.wr_en     = is_write && (32'(cur_slot_ff) < PALETTE_DEPTH);
      issue.rd_en     = fire;
      issue.in_range  = in_range;
      issue.last_word = last;
      issue.last_sect = end_sec;
      issue_idx   = idx;
      issue_entry = cnt_ff;
      wr_addr     = AW'(cur_slot_ff);
      wr_value    = cur_value_ff;

      cur_valid_in  = cur_valid_ff;
      cur_action_in = cur_action_ff;
      cur_slot_in   = cur_slot_ff;
      cur_value_in  = cur_value_ff;
      word_in       = word_ff;
      first_in      = first_ff;
      pos_in        = pos_ff;
      pend_in       = pend_ff;
      part_in       = part_ff;
      held_in       = held_ff;
      cnt_in        = cnt_ff;

      if (fire) begin
         word_in  = word_sh;
         pos_in   = pos_next;
         first_in = 1'b0;
         cnt_in   = end_sec ? '0 : cnt_ff + CW'(1);
         if (last) begin
            // leftover high bits wait for the next word in spanning mode
            pend_in = !end_sec && cfg.packing_mode
                      && (pos_next < 7'(piu_pkg::WORD_BITS));
            part_in = word_sh[15:0];
            held_in = 7'(piu_pkg::WORD_BITS) - pos_next;
         end else begin
            pend_in = 1'b0;
         end
      end

      if (accept) begin
         cur_valid_in  = 1'b1;
         cur_action_in = req_action;
         cur_slot_in   = req_palette_slot;
         cur_value_in  = req_palette_value;
         word_in       = req_packed_word;
         first_in      = 1'b1;
         pos_in        = 7'd0;
      end else if (cur_done) begin
         cur_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         pend_ff      <= 1'b0;
         cnt_ff       <= '0;
         part_ff      <= '0;
         held_ff      <= '0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         pend_ff      <= pend_in;
         cnt_ff       <= cnt_in;
         part_ff      <= part_in;
         held_ff      <= held_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_action_ff <= cur_action_in;
      cur_slot_ff   <= cur_slot_in;
      cur_value_ff  <= cur_value_in;
      word_ff       <= word_in;
      first_ff      <= first_in;
      pos_ff        <= pos_in;
   end

   `PIU_ASSERT_IMPLY(a_wr_rd_exclusive, clock, reset, issue.wr_en, !issue.rd_en, "palette write and read issued together")
   `PIU_ASSERT_IMPLY(a_pos_bound, clock, reset, is_data && !first_ff, pos_ff <= 7'd64, "bit position beyond the word")
   `PIU_ASSERT_IMPLY(a_pend_held, clock, reset, pend_ff, (held_ff != 7'd0) && (held_ff < 7'd64), "pending bits count out of range")
   `PIU_ASSERT_NEXT(a_issue_end_frees, clock, reset, fire && last && !accept, !cur_valid_ff, "transaction kept after its last index")

endmodule

>>> design/piu_lookup.sv
// ----------------------------------------------------------------------------
// piu_lookup
// palette memory, read stage and output register
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module piu_lookup #(
   parameter int SECTION_ENTRIES = piu_pkg::SECTION_ENTRIES_DEF,
   parameter int PALETTE_DEPTH   = piu_pkg::PALETTE_DEPTH_DEF,
   localparam int CW = $clog2(SECTION_ENTRIES),
   localparam int AW = $clog2(PALETTE_DEPTH)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  piu_pkg::issue_ctl_type issue,
   input  logic [15:0]            issue_idx,
   input  logic [CW-1:0]          issue_entry,
   input  logic [AW-1:0]          wr_addr,
   input  logic [7:0]             wr_value,
   output logic                   s1_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [7:0]             rsp_block_value,
   output logic [15:0]            rsp_raw_index,
   output logic                   rsp_index_in_range,
   output logic [CW-1:0]          rsp_entry_number,
   output logic                   rsp_last_of_word,
   output logic                   rsp_last_of_section
);

   logic [7:0] mem [PALETTE_DEPTH];
   logic [7:0] rdata_ff;

   logic          s1_valid_ff, s1_valid_in;
   logic [15:0]   s1_idx_ff;
   logic [CW-1:0] s1_entry_ff;
   logic          s1_in_range_ff, s1_last_word_ff, s1_last_sect_ff;

   logic          out_valid_ff, out_valid_in;
   logic [7:0]    out_value_ff;
   logic [15:0]   out_idx_ff;
   logic [CW-1:0] out_entry_ff;
   logic          out_in_range_ff, out_last_word_ff, out_last_sect_ff;

   logic out_load;

   always_comb begin
      out_load     = !out_valid_ff || !rsp_stall;
      s1_ready     = !s1_valid_ff || out_load;
      s1_valid_in  = s1_ready ? issue.rd_en : s1_valid_ff;
      out_valid_in = out_load ? s1_valid_ff : out_valid_ff;
   end

   // single port: a write and a read never share a cycle
   always_ff @(posedge clock) begin
      if (issue.wr_en) begin
         mem[wr_addr] <= wr_value;
      end
      if (issue.rd_en) begin
         rdata_ff <= mem[AW'(issue_idx)];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (issue.rd_en) begin
         s1_idx_ff       <= issue_idx;
         s1_entry_ff     <= issue_entry;
         s1_in_range_ff  <= issue.in_range;
         s1_last_word_ff <= issue.last_word;
         s1_last_sect_ff <= issue.last_sect;
      end
      if (out_load && s1_valid_ff) begin
         out_value_ff     <= s1_in_range_ff ? rdata_ff : 8'd0;
         out_idx_ff       <= s1_idx_ff;
         out_entry_ff     <= s1_entry_ff;
         out_in_range_ff  <= s1_in_range_ff;
         out_last_word_ff <= s1_last_word_ff;
         out_last_sect_ff <= s1_last_sect_ff;
      end
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_block_value     = out_value_ff;
   assign rsp_raw_index       = out_idx_ff;
   assign rsp_index_in_range  = out_in_range_ff;
   assign rsp_entry_number    = out_entry_ff;
   assign rsp_last_of_word    = out_last_word_ff;
   assign rsp_last_of_section = out_last_sect_ff;

   `PIU_ASSERT_IMPLY(a_read_has_room, clock, reset, issue.rd_en, s1_ready, "index issued into a full read stage")
   `PIU_ASSERT_NEXT(a_s1_holds, clock, reset, s1_valid_ff && !out_load, s1_valid_ff && $stable(s1_idx_ff), "blocked read stage lost its entry")
   `PIU_ASSERT_IMPLY(a_zero_out_of_range, clock, reset, out_valid_ff && !out_in_range_ff, out_value_ff == 8'd0, "out of range index gave a nonzero value")

endmodule

>>> design/packed_index_unpacker.sv
// ----------------------------------------------------------------------------
// packed_index_unpacker
// path: an accepted word is held in the issue stage; its indices then pass
// the read stage and the output register; throughput: one index per cycle
// while rsp_stall is low, set by the issue stage walking the held word; a
// word gives at most 64 / bits_per_index rounded down plus one spanning index
// reset: synchronous, clears control and unpacking state; palette undefined
// ----------------------------------------------------------------------------
module packed_index_unpacker #(
   parameter int SECTION_ENTRIES = piu_pkg::SECTION_ENTRIES_DEF,
   parameter int PALETTE_DEPTH   = piu_pkg::PALETTE_DEPTH_DEF,
   localparam int CW = $clog2(SECTION_ENTRIES),
   localparam int AW = $clog2(PALETTE_DEPTH)
) (
   input  logic          clock,
   input  logic          reset,
   // input transactions: palette writes and packed words
   input  logic          req_valid,
   output logic          req_stall,
   input  logic          req_action,
   input  logic [8:0]    req_palette_slot,
   input  logic [7:0]    req_palette_value,
   input  logic [63:0]   req_packed_word,
   // one result transaction per unpacked index
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output logic [7:0]    rsp_block_value,
   output logic [15:0]   rsp_raw_index,
   output logic          rsp_index_in_range,
   output logic [CW-1:0] rsp_entry_number,
   output logic          rsp_last_of_word,
   output logic          rsp_last_of_section,
   // register writes
   input  logic          csr_valid,
   output logic          csr_ready,
   input  logic [1:0]    csr_index,
   input  logic [9:0]    csr_data
);

   piu_pkg::cfg_type       cfg_ff, cfg_in;
   piu_pkg::issue_ctl_type issue;
   logic [15:0]            issue_idx;
   logic [CW-1:0]          issue_entry;
   logic [AW-1:0]          wr_addr;
   logic [7:0]             wr_value;
   logic                   s1_ready;

   // the user must write registers only while the block is idle; not enforced, so no hold-off here
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            piu_pkg::CSR_PACKING_MODE:   cfg_in.packing_mode   = csr_data[0];
            piu_pkg::CSR_BITS_PER_INDEX: cfg_in.bits_per_index = csr_data[4:0];
            piu_pkg::CSR_PALETTE_COUNT:  cfg_in.palette_count  = csr_data;
            default: ;  // unused index, write dropped
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.packing_mode   <= piu_pkg::RST_PACKING_MODE;
         cfg_ff.bits_per_index <= piu_pkg::RST_BITS_PER_INDEX;
         cfg_ff.palette_count  <= piu_pkg::RST_PALETTE_COUNT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // issue stage: holds the current transaction, walks the word index by
   // index, carries spanning bits across words and counts section entries;
   // a new transaction is taken in the cycle the current one finishes
   piu_unpack #(
      .SECTION_ENTRIES (SECTION_ENTRIES),
      .PALETTE_DEPTH   (PALETTE_DEPTH)
   ) u_unpack (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg_ff),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_action        (req_action),
      .req_palette_slot  (req_palette_slot),
      .req_palette_value (req_palette_value),
      .req_packed_word   (req_packed_word),
      .s1_ready          (s1_ready),
      .issue             (issue),
      .issue_idx         (issue_idx),
      .issue_entry       (issue_entry),
      .wr_addr           (wr_addr),
      .wr_value          (wr_value)
   );

   // palette memory with a registered read, then the output register that
   // decouples the result side; writes go in issue order behind earlier
   // reads, so an index always sees the palette as it stood at its word
   piu_lookup #(
      .SECTION_ENTRIES (SECTION_ENTRIES),
      .PALETTE_DEPTH   (PALETTE_DEPTH)
   ) u_lookup (
      .clock               (clock),
      .reset               (reset),
      .issue               (issue),
      .issue_idx           (issue_idx),
      .issue_entry         (issue_entry),
      .wr_addr             (wr_addr),
      .wr_value            (wr_value),
      .s1_ready            (s1_ready),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_block_value     (rsp_block_value),
      .rsp_raw_index       (rsp_raw_index),
      .rsp_index_in_range  (rsp_index_in_range),
      .rsp_entry_number    (rsp_entry_number),
      .rsp_last_of_word    (rsp_last_of_word),
      .rsp_last_of_section (rsp_last_of_section)
   );

endmodule

>>> tb/unpacked_index_checker.sv
// ----------------------------------------------------------------------------
// unpacked_index_checker
// watches the register, request and result channels of the unpacker, works
// out the indices each packed word should yield and compares every result
// transaction against the oldest one still due
// ----------------------------------------------------------------------------
module unpacked_index_checker
   import piu_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic        req_action,
   input  logic [8:0]  req_palette_slot,
   input  logic [7:0]  req_palette_value,
   input  logic [63:0] req_packed_word,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [7:0]  rsp_block_value,
   input  logic [15:0] rsp_raw_index,
   input  logic        rsp_index_in_range,
   input  logic [11:0] rsp_entry_number,
   input  logic        rsp_last_of_word,
   input  logic        rsp_last_of_section,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [9:0]  csr_data,
   output int unsigned outstanding,
   output int unsigned fault_count
);

   typedef struct {
      logic [7:0]  block_value;
      logic [15:0] raw_index;
      logic        in_range;
      logic [11:0] entry_number;
      logic        last_word;
      logic        last_section;
   } index_entry_type;

   // own copy of the registers and unpacking state
   logic        cfg_mode;
   logic [4:0]  cfg_bits;
   logic [9:0]  cfg_count;
   logic [7:0]  palette_mem [PALETTE_DEPTH_DEF];
   int unsigned held_bits;
   logic [15:0] carry_bits;
   logic        carry_pending;
   int unsigned entry_cnt;

   index_entry_type due_entries [$];
   index_entry_type staged;
   bit              staged_valid;
   int unsigned     faults;

   // queue one expected result behind those already due
   function void append_due(input index_entry_type e);
      due_entries.insert(due_entries.size(), e);
   endfunction

   // one index leaves the word; held back a step so the word's last can be marked
   function void stage_index(input logic [15:0] idx, output bit sect_end);
      int unsigned     lim;
      index_entry_type e;
      lim = (cfg_count < PALETTE_DEPTH_DEF) ? cfg_count : PALETTE_DEPTH_DEF;
      e.in_range     = (idx < lim);
      e.block_value  = e.in_range ? palette_mem[idx[8:0]] : 8'd0;
      e.raw_index    = idx;
      e.entry_number = entry_cnt[11:0];
      e.last_word    = 1'b0;
      sect_end       = (entry_cnt + 1 >= SECTION_ENTRIES_DEF);
      e.last_section = sect_end;
      entry_cnt      = sect_end ? 0 : entry_cnt + 1;
      if (staged_valid) append_due(staged);
      staged       = e;
      staged_valid = 1'b1;
   endfunction

   function void unpack_word(input logic [63:0] word);
      int unsigned w;
      int unsigned pos;
      int unsigned held;
      logic [63:0] msk;
      logic [63:0] chunk;
      bit          ended;
      w = cfg_bits;
      if (w < 1) w = 1;
      if (w > MAX_INDEX_BITS) w = MAX_INDEX_BITS;
      msk = (64'd1 << w) - 64'd1;
      pos = 0;
      ended = 1'b0;
      staged_valid = 1'b0;
      // spanning index: held low bits joined with the bottom of this word
      if (cfg_mode && carry_pending) begin
         held = held_bits & 63;
         chunk = ({48'd0, carry_bits} | (word << held)) & msk;
         pos = (w > held) ? w - held : 0;
         carry_pending = 1'b0;
         stage_index(chunk[15:0], ended);
      end
      carry_pending = 1'b0;
      held_bits = 0;
      while (!ended && pos + w <= WORD_BITS) begin
         chunk = (word >> pos) & msk;
         pos += w;
         stage_index(chunk[15:0], ended);
      end
      if (!ended && cfg_mode && pos < WORD_BITS) begin
         chunk = word >> pos;
         carry_bits = chunk[15:0];
         held_bits = WORD_BITS - pos;
         carry_pending = 1'b1;
      end else begin
         carry_bits = 16'd0;
      end
      if (staged_valid) begin
         staged.last_word = 1'b1;
         append_due(staged);
      end
   endfunction

   always @(posedge clock) begin
      index_entry_type got;
      index_entry_type want;
      if (reset) begin
         cfg_mode = RST_PACKING_MODE;
         cfg_bits = RST_BITS_PER_INDEX;
         cfg_count = RST_PALETTE_COUNT;
         held_bits = 0;
         carry_bits = 16'd0;
         carry_pending = 1'b0;
         entry_cnt = 0;
         due_entries.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_PACKING_MODE:   cfg_mode = csr_data[0];
               CSR_BITS_PER_INDEX: cfg_bits = csr_data[4:0];
               CSR_PALETTE_COUNT:  cfg_count = csr_data;
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            if (req_action == ACT_DATA_WORD) unpack_word(req_packed_word);
            else palette_mem[req_palette_slot] = req_palette_value;
         end
         if (rsp_valid && !rsp_stall) begin
            got.block_value  = rsp_block_value;
            got.raw_index    = rsp_raw_index;
            got.in_range     = rsp_index_in_range;
            got.entry_number = rsp_entry_number;
            got.last_word    = rsp_last_of_word;
            got.last_section = rsp_last_of_section;
            if (due_entries.size() == 0) begin
               faults++;
               if (faults <= 10)
                  $display("unexpected result: value %0h index %0h entry %0d",
                           got.block_value, got.raw_index, got.entry_number);
            end else begin
               want = due_entries.pop_front();
               if (got.block_value !== want.block_value || got.raw_index !== want.raw_index
                   || got.in_range !== want.in_range
                   || got.entry_number !== want.entry_number
                   || got.last_word !== want.last_word
                   || got.last_section !== want.last_section) begin
                  faults++;
                  if (faults <= 10) begin
                     $display("mismatch expected: value %0h index %0h in %0b entry %0d lw %0b ls %0b",
                              want.block_value, want.raw_index, want.in_range,
                              want.entry_number, want.last_word, want.last_section);
                     $display("         actual:   value %0h index %0h in %0b entry %0d lw %0b ls %0b",
                              got.block_value, got.raw_index, got.in_range,
                              got.entry_number, got.last_word, got.last_section);
                  end
               end
            end
         end
      end
      outstanding <= due_entries.size();
      fault_count <= faults;
   end

endmodule

>>> tb/tb_packed_index_unpacker.sv
// ----------------------------------------------------------------------------
// tb_packed_index_unpacker
// drives palette writes, packed words and register writes into the unpacker
// with random idling on both channels; a checker beside the block predicts
// and compares every result, and this top gives the verdict
// ----------------------------------------------------------------------------
module tb_packed_index_unpacker;
   import piu_pkg::*;

   // palette entries loaded up front; random counts never reach past them
   localparam int LOADED_ENTRIES = 128;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic        req_action;
   logic [8:0]  req_palette_slot;
   logic [7:0]  req_palette_value;
   logic [63:0] req_packed_word;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [7:0]  rsp_block_value;
   logic [15:0] rsp_raw_index;
   logic        rsp_index_in_range;
   logic [11:0] rsp_entry_number;
   logic        rsp_last_of_word;
   logic        rsp_last_of_section;
   logic        csr_valid;
   logic        csr_ready;
   logic [1:0]  csr_index;
   logic [9:0]  csr_data;

   int unsigned outstanding;
   int unsigned fault_count;
   logic        calm;          // switches all idling off for a stretch
   logic [11:0] seen_entry;    // entry number of the last accepted result
   logic        seen_any;

   packed_index_unpacker uut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_action          (req_action),
      .req_palette_slot    (req_palette_slot),
      .req_palette_value   (req_palette_value),
      .req_packed_word     (req_packed_word),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_block_value     (rsp_block_value),
      .rsp_raw_index       (rsp_raw_index),
      .rsp_index_in_range  (rsp_index_in_range),
      .rsp_entry_number    (rsp_entry_number),
      .rsp_last_of_word    (rsp_last_of_word),
      .rsp_last_of_section (rsp_last_of_section),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_data            (csr_data)
   );

   unpacked_index_checker watch (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_action          (req_action),
      .req_palette_slot    (req_palette_slot),
      .req_palette_value   (req_palette_value),
      .req_packed_word     (req_packed_word),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_block_value     (rsp_block_value),
      .rsp_raw_index       (rsp_raw_index),
      .rsp_index_in_range  (rsp_index_in_range),
      .rsp_entry_number    (rsp_entry_number),
      .rsp_last_of_word    (rsp_last_of_word),
      .rsp_last_of_section (rsp_last_of_section),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_data            (csr_data),
      .outstanding         (outstanding),
      .fault_count         (fault_count)
   );

   // 20 unit clock period
   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // result side back-pressure, roughly 15 percent of the time unless calm
   always @(posedge clock) begin
      rsp_stall <= !calm && ($urandom_range(0, 99) < 15);
   end

   // remember where the section counter stands, used to steer towards a wrap
   always @(posedge clock) begin
      if (rsp_valid && !rsp_stall) begin
         seen_entry <= rsp_entry_number;
         seen_any   <= 1'b1;
      end
   end

   // hard limit on the whole run
   initial begin
      #20_000_000;
      $display("status: fail");
      $finish;
   end

   // present one transaction and hold it until it is taken; random idle before
   task automatic send(input logic act, input logic [8:0] slot, input logic [7:0] value,
                       input logic [63:0] word);
      while (!calm && $urandom_range(0, 99) < 15) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_action        <= act;
      req_palette_slot  <= slot;
      req_palette_value <= value;
      req_packed_word   <= word;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // unused fields carry random bits, the block should ignore them
   task automatic push_word(input logic [63:0] word);
      send(ACT_DATA_WORD, 9'($urandom_range(0, 511)), 8'($urandom_range(0, 255)), word);
   endtask

   task automatic push_palette(input logic [8:0] slot, input logic [7:0] value);
      send(ACT_PALETTE_WRITE, slot, value, {$urandom, $urandom});
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [9:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // wait until every predicted result has come back, then let palette writes settle
   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (8) @(posedge clock);
   endtask

   function automatic logic [63:0] random_word();
      case ($urandom_range(0, 5))
         0:       return '1;
         1:       return '0;
         2:       return {$urandom, $urandom} & {$urandom, $urandom};
         3:       return {$urandom, $urandom} | {$urandom, $urandom};
         default: return {$urandom, $urandom};
      endcase
   endfunction

   // mostly legal widths, now and then the clamped ones
   function automatic logic [4:0] random_width();
      if ($urandom_range(0, 9) == 0) return 5'($urandom_range(0, 31));
      return 5'($urandom_range(1, 16));
   endfunction

   // counts stay inside the loaded part of the palette
   function automatic logic [9:0] random_count();
      case ($urandom_range(0, 4))
         0:       return 10'd0;
         1:       return 10'(LOADED_ENTRIES);
         2:       return 10'($urandom_range(1, 16));
         default: return 10'($urandom_range(0, LOADED_ENTRIES));
      endcase
   endfunction

   initial begin
      int          k;
      int          left;
      int unsigned rand_items;
      int unsigned phase_no;
      int unsigned phase_len;
      logic [63:0] pattern;
      logic [9:0]  junk;

      reset             = 1'b1;
      calm              = 1'b0;
      seen_any          = 1'b0;
      seen_entry        = '0;
      rsp_stall         = 1'b0;
      req_valid         = 1'b0;
      req_action        = ACT_PALETTE_WRITE;
      req_palette_slot  = '0;
      req_palette_value = '0;
      req_packed_word   = '0;
      csr_valid         = 1'b0;
      csr_index         = CSR_PACKING_MODE;
      csr_data          = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // load the low palette entries; larger counts below only ever meet
      // entries written just before, so no unwritten entry is looked up
      for (k = 0; k < LOADED_ENTRIES; k++)
         push_palette(9'(k), 8'($urandom_range(0, 255)));

      // directed: reset settings, 4-bit indices with nothing in range
      push_word('1);
      push_word('0);

      // 9-bit indices reach the top palette entry, leftover bit skipped
      drain();
      write_reg(CSR_PALETTE_COUNT, 10'd512);
      write_reg(CSR_BITS_PER_INDEX, 10'd9);
      push_palette(9'd511, 8'd255);
      push_palette(9'd0, 8'd0);
      push_word('1);
      push_word('0);

      // count above the table depth: 600 is below the count yet out of range
      drain();
      write_reg(CSR_PALETTE_COUNT, 10'd1023);
      write_reg(CSR_BITS_PER_INDEX, 10'd10);
      for (k = 0; k < 6; k++) pattern[k*10 +: 10] = (k % 2 != 0) ? 10'd511 : 10'd600;
      pattern[63:60] = 4'hf;
      push_word(pattern);

      // width zero behaves as one, widths past sixteen behave as sixteen
      drain();
      write_reg(CSR_BITS_PER_INDEX, 10'd0);
      push_word({$urandom, $urandom});
      drain();
      write_reg(CSR_BITS_PER_INDEX, 10'd17);
      push_word('1);
      drain();
      write_reg(CSR_BITS_PER_INDEX, 10'd31);
      // indices land either in the loaded entries or far beyond the table
      push_word({$urandom, $urandom} & 64'h803f_803f_803f_803f);

      // spanning mode with 5-bit indices, four bits carry into the next word
      drain();
      write_reg(CSR_PACKING_MODE, 10'd1);
      write_reg(CSR_BITS_PER_INDEX, 10'd5);
      write_reg(CSR_PALETTE_COUNT, 10'd20);
      repeat (3) push_word({$urandom, $urandom});

      // width grows while bits are held, then shrinks to equal the held count
      drain();
      write_reg(CSR_BITS_PER_INDEX, 10'd7);
      push_word({$urandom, $urandom});
      drain();
      write_reg(CSR_BITS_PER_INDEX, 10'd3);
      push_word({$urandom, $urandom});

      // leaving spanning mode with a partial index held drops it
      drain();
      write_reg(CSR_PACKING_MODE, 10'd0);
      push_word({$urandom, $urandom});

      // sixteen bits divide the word exactly, nothing ever spans
      drain();
      write_reg(CSR_PACKING_MODE, 10'd1);
      write_reg(CSR_BITS_PER_INDEX, 10'd16);
      push_word({$urandom, $urandom});
      push_word('1);
      drain();
      write_reg(CSR_PALETTE_COUNT, 10'd0);
      push_word('1);

      // run the section counter up to its wrap and let it land mid-word in
      // spanning mode, so the rest of the word and the held bits are dropped
      drain();
      left = 4096 - (seen_any ? (int'(seen_entry) + 1) % 4096 : 0);
      write_reg(CSR_PACKING_MODE, 10'd0);
      write_reg(CSR_BITS_PER_INDEX, 10'd1);
      write_reg(CSR_PALETTE_COUNT, 10'd300);
      while (left > 100) begin
         push_word(random_word());
         left -= 64;
      end
      drain();
      write_reg(CSR_PACKING_MODE, 10'd1);
      write_reg(CSR_BITS_PER_INDEX, 10'd7);
      repeat (14) push_word({$urandom, $urandom});

      // random phases, each under its own register settings; one phase calm
      rand_items = 0;
      phase_no = 0;
      while (rand_items < 240) begin
         drain();
         calm <= (phase_no == 4);
         if (phase_no == 0 || $urandom_range(0, 99) < 70) begin
            junk = ($urandom_range(0, 3) == 0) ? 10'($urandom_range(0, 1023)) : 10'd0;
            write_reg(CSR_PACKING_MODE, {junk[9:1], 1'($urandom_range(0, 1))});
         end
         if (phase_no == 0 || $urandom_range(0, 99) < 70) begin
            junk = ($urandom_range(0, 3) == 0) ? 10'($urandom_range(0, 1023)) : 10'd0;
            write_reg(CSR_BITS_PER_INDEX, {junk[9:5], random_width()});
         end
         if (phase_no == 0 || $urandom_range(0, 99) < 70)
            write_reg(CSR_PALETTE_COUNT, random_count());
         phase_len = $urandom_range(10, 45);
         for (k = 0; k < phase_len; k++) begin
            if ($urandom_range(0, 99) < 15)
               push_palette(9'($urandom_range(0, 511)), 8'($urandom_range(0, 255)));
            else
               push_word(random_word());
         end
         rand_items += phase_len;
         phase_no++;
      end

      calm <= 1'b0;
      drain();
      if (fault_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

>>> files.f
+incdir+design
design/piu_pkg.sv
design/piu_unpack.sv
design/piu_lookup.sv
design/packed_index_unpacker.sv
tb/unpacked_index_checker.sv
tb/tb_packed_index_unpacker.sv
